FILE: rtl/acdar_pkg.sv
// shared types and constants for the age-replaced associative directory
`timescale 1ns / 1ps

package acdar_pkg;

   localparam int AGE_W   = 14;
   localparam int SLOT_W  = 4;
   localparam int FIELD_W = 32;

   localparam logic [AGE_W-1:0] AGE_FRESH = AGE_W'(9999);

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } acdar_state_type;

   // control part of the scan packet handed from cell to cell
   typedef struct packed {
      logic vld;
      logic found;
      logic empty_found;
      logic have_min;
   } scan_flags_type;

endpackage

FILE: rtl/acdar_cell.sv
// one directory entry plus its stage of the scan packet chain
`timescale 1ns / 1ps

module acdar_cell #(
   parameter int IDX_W        = 4,
   parameter int KEY_BITS     = 32,
   parameter int PAYLOAD_BITS = 32,
   parameter int CELL_IDX     = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   // scan packet from the previous cell
   input  acdar_pkg::scan_flags_type     in_flags,
   input  logic [IDX_W-1:0]              in_idx,
   input  logic [PAYLOAD_BITS-1:0]       in_pay,
   input  logic [IDX_W-1:0]              in_empty_idx,
   input  logic [acdar_pkg::AGE_W-1:0]   in_min_age,
   input  logic [IDX_W-1:0]              in_min_idx,
   // scan packet to the next cell
   output acdar_pkg::scan_flags_type     out_flags,
   output logic [IDX_W-1:0]              out_idx,
   output logic [PAYLOAD_BITS-1:0]       out_pay,
   output logic [IDX_W-1:0]              out_empty_idx,
   output logic [acdar_pkg::AGE_W-1:0]   out_min_age,
   output logic [IDX_W-1:0]              out_min_idx,
   // broadcast from the controller
   input  logic [KEY_BITS-1:0]           key,
   input  logic [PAYLOAD_BITS-1:0]       payload,
   input  logic                          commit,
   input  logic [IDX_W-1:0]              commit_idx
);
   import acdar_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic                    valid_ff, valid_in;
   logic [KEY_BITS-1:0]     entry_key_ff, entry_key_in;
   logic [PAYLOAD_BITS-1:0] entry_pay_ff, entry_pay_in;
   logic [AGE_W-1:0]        age_ff, age_in;

   logic                    scan_vld_ff;
   scan_flags_type          flags_ff, flags_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;
   logic [IDX_W-1:0]        empty_idx_ff, empty_idx_in;
   logic [AGE_W-1:0]        min_age_ff, min_age_in;
   logic [IDX_W-1:0]        min_idx_ff, min_idx_in;

   // scan step: first match, first empty slot and running minimum age
   always_comb begin
      flags_in     = in_flags;
      idx_in       = in_idx;
      pay_in       = in_pay;
      empty_idx_in = in_empty_idx;
      min_age_in   = in_min_age;
      min_idx_in   = in_min_idx;
      if (!in_flags.found && valid_ff && (entry_key_ff == key)) begin
         flags_in.found = 1'b1;
         idx_in         = MY_IDX;
         pay_in         = entry_pay_ff;
      end
      if (!in_flags.empty_found && !valid_ff) begin
         flags_in.empty_found = 1'b1;
         empty_idx_in         = MY_IDX;
      end
      // strict compare keeps the lowest index on equal ages
      if (valid_ff && (!in_flags.have_min || (age_ff < in_min_age))) begin
         flags_in.have_min = 1'b1;
         min_age_in        = age_ff;
         min_idx_in        = MY_IDX;
      end
   end

   // entry update on an insert commit
   always_comb begin
      valid_in     = valid_ff;
      entry_key_in = entry_key_ff;
      entry_pay_in = entry_pay_ff;
      age_in       = age_ff;
      if (commit) begin
         if (commit_idx == MY_IDX) begin
            valid_in     = 1'b1;
            entry_key_in = key;
            entry_pay_in = payload;
            age_in       = AGE_FRESH;
         end else if (valid_ff && (age_ff != '0)) begin
            age_in = age_ff - AGE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         age_ff      <= '0;
         scan_vld_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         age_ff      <= age_in;
         scan_vld_ff <= in_flags.vld;
      end
   end

   always_ff @(posedge clock) begin
      entry_key_ff <= entry_key_in;
      entry_pay_ff <= entry_pay_in;
      if (in_flags.vld) begin
         flags_ff     <= flags_in;
         idx_ff       <= idx_in;
         pay_ff       <= pay_in;
         empty_idx_ff <= empty_idx_in;
         min_age_ff   <= min_age_in;
         min_idx_ff   <= min_idx_in;
      end
   end

   // the packet marker is the only reset part of the packet
   always_comb begin
      out_flags     = flags_ff;
      out_flags.vld = scan_vld_ff;
   end

   assign out_idx       = idx_ff;
   assign out_pay       = pay_ff;
   assign out_empty_idx = empty_idx_ff;
   assign out_min_age   = min_age_ff;
   assign out_min_idx   = min_idx_ff;

endmodule

FILE: rtl/assoc_cache_directory_age_replace.sv
// the scan packet is registered in start_ff, then walks the cell chain one cell per cycle
// before the result is known and loaded into the output register; req_ready stays low
// from the accept until that load, so a new transaction waits until the last one is done
// an insert updates the entries in the cycle its result enters the output register
// reset empties every entry and clears all ages; no clearing pass is needed
`timescale 1ns / 1ps

module assoc_cache_directory_age_replace #(
   parameter int ENTRIES      = 16,
   parameter int KEY_BITS     = 32,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_command,
   input  logic [acdar_pkg::FIELD_W-1:0]   req_key,
   input  logic [acdar_pkg::FIELD_W-1:0]   req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_hit,
   output logic [acdar_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [acdar_pkg::FIELD_W-1:0]   rsp_payload_out
);
   import acdar_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);

   acdar_state_type         state_ff, state_in;
   logic                    start_ff, start_in;
   logic                    cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic [SLOT_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic [FIELD_W-1:0]      rsp_payload_ff, rsp_payload_in;

   logic                    accept;
   logic                    out_free;
   logic                    load_rsp;
   logic                    commit;
   logic [IDX_W-1:0]        victim;

   scan_flags_type          flags_w     [0:ENTRIES];
   logic [IDX_W-1:0]        idx_w       [0:ENTRIES];
   logic [PAYLOAD_BITS-1:0] pay_w       [0:ENTRIES];
   logic [IDX_W-1:0]        empty_idx_w [0:ENTRIES];
   logic [AGE_W-1:0]        min_age_w   [0:ENTRIES];
   logic [IDX_W-1:0]        min_idx_w   [0:ENTRIES];

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (flags_w[ENTRIES].vld) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_SCAN: req_ready = 1'b0;
         ST_DONE: load_rsp  = out_free;
         default: req_ready = 1'b0;
      endcase
   end

   assign commit   = load_rsp && (cmd_ff == CMD_INSERT);
   assign start_in = accept;
   assign cmd_in   = accept ? req_command : cmd_ff;
   assign key_in   = accept ? KEY_BITS'(req_key) : key_ff;
   assign pay_in   = accept ? PAYLOAD_BITS'(req_payload) : pay_ff;

   // first empty slot wins, otherwise the oldest entry
   assign victim = flags_w[ENTRIES].empty_found ? empty_idx_w[ENTRIES]
                                                : min_idx_w[ENTRIES];

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_payload_in = rsp_payload_ff;
      if (load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_hit_in     = 1'b0;
         rsp_slot_in    = '0;
         rsp_payload_in = '0;
         if (cmd_ff == CMD_INSERT) begin
            rsp_slot_in = SLOT_W'(victim);
         end else if (flags_w[ENTRIES].found) begin
            rsp_hit_in     = 1'b1;
            rsp_slot_in    = SLOT_W'(idx_w[ENTRIES]);
            rsp_payload_in = FIELD_W'(pay_w[ENTRIES]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      key_ff         <= key_in;
      pay_ff         <= pay_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // empty scan packet enters the head of the chain
   assign flags_w[0]     = '{vld: start_ff, found: 1'b0, empty_found: 1'b0, have_min: 1'b0};
   assign idx_w[0]       = '0;
   assign pay_w[0]       = '0;
   assign empty_idx_w[0] = '0;
   assign min_age_w[0]   = '0;
   assign min_idx_w[0]   = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      acdar_cell #(
         .IDX_W        (IDX_W),
         .KEY_BITS     (KEY_BITS),
         .PAYLOAD_BITS (PAYLOAD_BITS),
         .CELL_IDX     (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .in_flags      (flags_w[i]),
         .in_idx        (idx_w[i]),
         .in_pay        (pay_w[i]),
         .in_empty_idx  (empty_idx_w[i]),
         .in_min_age    (min_age_w[i]),
         .in_min_idx    (min_idx_w[i]),
         .out_flags     (flags_w[i+1]),
         .out_idx       (idx_w[i+1]),
         .out_pay       (pay_w[i+1]),
         .out_empty_idx (empty_idx_w[i+1]),
         .out_min_age   (min_age_w[i+1]),
         .out_min_idx   (min_idx_w[i+1]),
         .key           (key_ff),
         .payload       (pay_ff),
         .commit        (commit),
         .commit_idx    (victim)
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_payload_out = rsp_payload_ff;

endmodule

FILE: tb/assoc_cache_directory_age_replace_tb.sv
// self-checking bench for the age-replaced associative directory
`timescale 1ns / 1ps

module assoc_cache_directory_age_replace_tb;
   import acdar_pkg::*;

   localparam int ENTRIES      = 16;
   localparam int KEY_BITS     = 32;
   localparam int PAYLOAD_BITS = 32;
   localparam int KEY_POOL     = 20;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic               hit;
      logic [SLOT_W-1:0]  slot;
      logic [FIELD_W-1:0] handle;
   } dir_reply_type;

   // mirror of the directory contents, one expected reply per transaction
   class directory_tracker;
      bit                 slot_valid[ENTRIES];
      logic [FIELD_W-1:0] slot_key[ENTRIES];
      logic [FIELD_W-1:0] slot_handle[ENTRIES];
      logic [AGE_W-1:0]   slot_age[ENTRIES];
      dir_reply_type      pending_replies[$];
      int                 errors;

      function new();
         foreach (slot_valid[i]) begin
            slot_valid[i]  = 1'b0;
            slot_key[i]    = '0;
            slot_handle[i] = '0;
            slot_age[i]    = '0;
         end
         errors = 0;
      endfunction

      // first empty slot, else oldest by age with the lowest index on ties
      function int pick_victim();
         int i;
         int best;
         best = -1;
         for (i = 0; i < ENTRIES; i++) begin
            if (best < 0 && !slot_valid[i]) best = i;
         end
         if (best >= 0) return best;
         best = 0;
         for (i = 1; i < ENTRIES; i++) begin
            if (slot_age[i] < slot_age[best]) best = i;
         end
         return best;
      endfunction

      function void note_request(logic cmd, logic [FIELD_W-1:0] key,
                                 logic [FIELD_W-1:0] handle);
         dir_reply_type want;
         int i;
         int victim;
         want = '0;
         if (cmd == CMD_INSERT) begin
            victim = pick_victim();
            for (i = 0; i < ENTRIES; i++) begin
               if (i != victim && slot_valid[i] && slot_age[i] != 0)
                  slot_age[i] = slot_age[i] - 1'b1;
            end
            slot_valid[victim]  = 1'b1;
            slot_key[victim]    = key;
            slot_handle[victim] = handle;
            slot_age[victim]    = AGE_FRESH;
            want.slot = victim[SLOT_W-1:0];
         end else begin
            for (i = 0; i < ENTRIES; i++) begin
               if (!want.hit && slot_valid[i] && slot_key[i] == key) begin
                  want.hit    = 1'b1;
                  want.slot   = i[SLOT_W-1:0];
                  want.handle = slot_handle[i];
               end
            end
         end
         pending_replies.push_back(want);
      endfunction

      function void log_mismatch(string what);
         errors++;
         if (errors <= 10) $display("%0t: %s", $realtime, what);
      endfunction

      function void check_response(logic hit, logic [SLOT_W-1:0] slot,
                                   logic [FIELD_W-1:0] handle);
         dir_reply_type want;
         if (pending_replies.size() == 0) begin
            log_mismatch($sformatf("unexpected reply hit=%0b slot=%0d payload=%h",
                                   hit, slot, handle));
         end else begin
            want = pending_replies.pop_front();
            if (want.hit !== hit || want.slot !== slot || want.handle !== handle)
               log_mismatch($sformatf(
                  "mismatch: expected hit=%0b slot=%0d payload=%h, got hit=%0b slot=%0d payload=%h",
                  want.hit, want.slot, want.handle, hit, slot, handle));
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_command = CMD_LOOKUP;
   logic [FIELD_W-1:0] req_key = '0;
   logic [FIELD_W-1:0] req_payload = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_hit;
   logic [SLOT_W-1:0]  rsp_slot;
   logic [FIELD_W-1:0] rsp_payload_out;

   directory_tracker   tracker = new();
   int                 req_idle_pct = 0;
   int                 rsp_idle_pct = 0;
   int                 cycle_count = 0;
   logic [FIELD_W-1:0] key_pool[KEY_POOL];

   assoc_cache_directory_age_replace #(
      .ENTRIES      (ENTRIES),
      .KEY_BITS     (KEY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_key         (req_key),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_slot        (rsp_slot),
      .rsp_payload_out (rsp_payload_out)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // handshake values are stable at the falling edge, ahead of the edge that takes them
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_response(rsp_hit, rsp_slot, rsp_payload_out);
   end

   initial begin : rsp_backpressure
      int n;
      forever begin
         @(posedge clock);
         if (!reset && rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
            n = $urandom_range(1, 10);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // called at a rising edge, returns at the edge that accepts the transaction
   task automatic issue_request(logic cmd, logic [FIELD_W-1:0] key,
                                logic [FIELD_W-1:0] handle);
      int n;
      if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         n = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_key     <= key;
      req_payload <= handle;
      do @(negedge clock); while (!req_ready);
      tracker.note_request(cmd, key, handle);
      @(posedge clock);
   endtask

   // mostly keys from a small pool so lookups hit and inserts duplicate
   task automatic run_random(int count);
      int n;
      logic cmd;
      logic [FIELD_W-1:0] key;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(0, 19) == 0) key_pool[$urandom_range(0, KEY_POOL - 1)] = $urandom;
         cmd = ($urandom_range(0, 99) < 45) ? CMD_INSERT : CMD_LOOKUP;
         key = ($urandom_range(0, 9) == 0) ? $urandom
                                            : key_pool[$urandom_range(0, KEY_POOL - 1)];
         issue_request(cmd, key, $urandom);
      end
   endtask

   initial begin : stimulus
      int i;
      foreach (key_pool[k]) key_pool[k] = $urandom;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 20;
      rsp_idle_pct = 5;
      // lookups on an empty directory
      issue_request(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      issue_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // extreme keys and handles
      issue_request(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
      issue_request(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
      issue_request(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      issue_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
      // duplicate insert, lookup must report the lower slot
      issue_request(CMD_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);
      issue_request(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
      issue_request(CMD_LOOKUP, 32'h1234_5678, 32'hFFFF_FFFF);
      // fill the rest, then evict the oldest slot
      for (i = 0; i < ENTRIES - 3; i++)
         issue_request(CMD_INSERT, 32'h0000_0001 << (i + 3), ~(32'h0000_0001 << i));
      issue_request(CMD_INSERT, 32'hC001_D00D, 32'h8000_0001);
      issue_request(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      issue_request(CMD_LOOKUP, 32'hC001_D00D, 32'h0000_0000);

      req_idle_pct = 30;
      rsp_idle_pct = 15;
      run_random(600);
      req_idle_pct = 10;
      rsp_idle_pct = 5;
      run_random(650);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(400);
      req_valid <= 1'b0;

      while (tracker.pending_replies.size() != 0) @(posedge clock);
      repeat (ENTRIES + 8) @(posedge clock);
      if (tracker.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: assoc_cache_directory_age_replace.f
rtl/acdar_pkg.sv
rtl/acdar_cell.sv
rtl/assoc_cache_directory_age_replace.sv
tb/assoc_cache_directory_age_replace_tb.sv
